@@ hdl/lsms_pkg.sv @@
// Shared types and constants for the LCD scanline mode sequencer.
package lsms_pkg;

    localparam int CfgWidth   = 10;
    localparam int LineWidth  = 8;
    localparam int NumRegs    = 5;
    localparam int IndexWidth = 3;

    // Register indexes on the configuration port
    localparam logic [IndexWidth-1:0] REG_OAM        = 3'd0;
    localparam logic [IndexWidth-1:0] REG_PIXEL      = 3'd1;
    localparam logic [IndexWidth-1:0] REG_HBLANK     = 3'd2;
    localparam logic [IndexWidth-1:0] REG_LINE       = 3'd3;
    localparam logic [IndexWidth-1:0] REG_SHORT_LINE = 3'd4;

    // Register reset values
    localparam logic [CfgWidth-1:0] OAM_RESET        = 10'd80;
    localparam logic [CfgWidth-1:0] PIXEL_RESET      = 10'd172;
    localparam logic [CfgWidth-1:0] HBLANK_RESET     = 10'd204;
    localparam logic [CfgWidth-1:0] LINE_RESET       = 10'd456;
    localparam logic [CfgWidth-1:0] SHORT_LINE_RESET = 10'd56;

    // Vblank lines that precede the lines with special lengths
    localparam logic [LineWidth-1:0] LAST_SHORT_PREV = 8'd152;
    localparam logic [LineWidth-1:0] LAST_LINE       = 8'd153;

    // Status mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_PIXEL  = 2'd3;

    typedef enum logic [4:0] {
        PH_OFF    = 5'b00001,
        PH_OAM    = 5'b00010,
        PH_PIXEL  = 5'b00100,
        PH_HBLANK = 5'b01000,
        PH_VBLANK = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [CfgWidth-1:0] oam_cycles;
        logic [CfgWidth-1:0] pixel_cycles;
        logic [CfgWidth-1:0] hblank_cycles;
        logic [CfgWidth-1:0] line_cycles;
        logic [CfgWidth-1:0] short_line_cycles;
    } cfg_t;

    typedef struct packed {
        logic                 lcd_enable;
        logic [LineWidth-1:0] lyc_value;
        logic                 irq_on_lyc;
        logic                 irq_on_oam;
        logic                 irq_on_vblank;
        logic                 irq_on_hblank;
    } item_t;

    typedef struct packed {
        phase_t               phase;
        logic [CfgWidth-1:0]  countdown;
        logic [LineWidth-1:0] line_counter;
        logic [1:0]           mode;
        logic                 coincidence;
        logic                 invalid_frame;
    } seq_state_t;

    typedef struct packed {
        logic [1:0]           mode_bits;
        logic [LineWidth-1:0] line_number;
        logic                 lyc_match;
        logic                 stat_irq;
        logic                 vblank_irq;
        logic                 render_line;
        logic                 frame_ready;
        logic                 display_on;
    } result_t;

endpackage

@@ hdl/lsms_cfg.sv @@
// Timing configuration registers of the scanline sequencer.
module lsms_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lsms_pkg::IndexWidth-1:0] cfg_index,
    input  logic [lsms_pkg::CfgWidth-1:0]   cfg_data,
    output lsms_pkg::cfg_t                  cfg
);
    import lsms_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.oam_cycles        <= OAM_RESET;
            cfg_reg.pixel_cycles      <= PIXEL_RESET;
            cfg_reg.hblank_cycles     <= HBLANK_RESET;
            cfg_reg.line_cycles       <= LINE_RESET;
            cfg_reg.short_line_cycles <= SHORT_LINE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OAM:        cfg_reg.oam_cycles        <= cfg_data;
                REG_PIXEL:      cfg_reg.pixel_cycles      <= cfg_data;
                REG_HBLANK:     cfg_reg.hblank_cycles     <= cfg_data;
                REG_LINE:       cfg_reg.line_cycles       <= cfg_data;
                REG_SHORT_LINE: cfg_reg.short_line_cycles <= cfg_data;
                default:        ; // unknown index: dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hdl/lsms_step.sv @@
// Next-state and result logic for one controller tick.
module lsms_step
#(
    parameter int VISIBLE_LINES = 144
)
(
    input  lsms_pkg::seq_state_t st,
    input  lsms_pkg::item_t      item,
    input  lsms_pkg::cfg_t       cfg,
    output lsms_pkg::seq_state_t nx,
    output lsms_pkg::result_t    res
);
    import lsms_pkg::*;

    localparam logic [LineWidth-1:0] VisLines   = VISIBLE_LINES[LineWidth-1:0];
    localparam logic [LineWidth-1:0] VisLinesM1 = VisLines - 8'd1;

    // zero length behaves as one tick
    function automatic logic [CfgWidth-1:0] dur(input logic [CfgWidth-1:0] v);
        return (v == '0) ? CfgWidth'(1) : v;
    endfunction

    // returns {coincidence, stat request} for a new line value
    function automatic logic [1:0] line_eval(
        input logic [LineWidth-1:0] ly,
        input logic [LineWidth-1:0] lyc,
        input logic                 lyc_en,
        input logic                 vb_en
    );
        logic hit;
        logic supp;
        hit  = (ly == lyc);
        supp = ((ly == '0) || (ly > VisLines)) && vb_en;
        return {hit, hit && lyc_en && !supp};
    endfunction

    logic [LineWidth-1:0] hb_line;
    logic [LineWidth-1:0] vb_line;
    logic [1:0]           hb_eval;
    logic [1:0]           vb_eval;
    logic                 prev_match;
    logic                 stat;
    logic                 vbi;
    logic                 rend;
    logic                 frame;

    assign hb_line    = st.line_counter + 8'd1;
    assign vb_line    = (st.line_counter == LAST_LINE) ? '0 : hb_line;
    assign hb_eval    = line_eval(hb_line, item.lyc_value, item.irq_on_lyc,
                                  item.irq_on_vblank);
    assign vb_eval    = line_eval(vb_line, item.lyc_value, item.irq_on_lyc,
                                  item.irq_on_vblank);
    assign prev_match = (hb_line != '0) && ((hb_line - 8'd1) == item.lyc_value);

    always_comb
    begin
        nx    = st;
        stat  = 1'b0;
        vbi   = 1'b0;
        rend  = 1'b0;
        frame = 1'b0;
        if (st.countdown > CfgWidth'(1))
        begin
            nx.countdown = st.countdown - CfgWidth'(1);
        end
        else
        begin
            case (st.phase)
                PH_OFF:
                begin
                    if (item.lcd_enable)
                    begin
                        nx.phase         = PH_OAM;
                        nx.invalid_frame = 1'b1;
                        nx.countdown     = dur(cfg.oam_cycles);
                    end
                    else
                    begin
                        nx.countdown = dur(cfg.line_cycles);
                    end
                end
                PH_OAM:
                begin
                    nx.mode      = MODE_PIXEL;
                    nx.phase     = PH_PIXEL;
                    nx.countdown = dur(cfg.pixel_cycles);
                end
                PH_PIXEL:
                begin
                    rend = !st.invalid_frame;
                    stat = item.irq_on_hblank &&
                           (!item.irq_on_lyc || (st.line_counter != item.lyc_value));
                    nx.mode      = MODE_HBLANK;
                    nx.phase     = PH_HBLANK;
                    nx.countdown = dur(cfg.hblank_cycles);
                end
                PH_HBLANK:
                begin
                    nx.line_counter = hb_line;
                    nx.coincidence  = hb_eval[1];
                    if (hb_line == VisLines)
                    begin
                        frame = !st.invalid_frame;
                        vbi   = 1'b1;
                        stat  = hb_eval[0] ||
                                (item.irq_on_vblank && !item.irq_on_hblank &&
                                 (!item.irq_on_lyc || (item.lyc_value != VisLinesM1)));
                        nx.mode      = MODE_VBLANK;
                        nx.phase     = PH_VBLANK;
                        nx.countdown = dur(cfg.line_cycles);
                    end
                    else
                    begin
                        stat = hb_eval[0] ||
                               (item.irq_on_oam && (!item.irq_on_lyc || !prev_match) &&
                                !item.irq_on_hblank);
                        nx.mode      = MODE_OAM;
                        nx.phase     = PH_OAM;
                        nx.countdown = dur(cfg.oam_cycles);
                    end
                end
                PH_VBLANK:
                begin
                    if (st.line_counter == '0)
                    begin
                        if (item.lcd_enable)
                        begin
                            nx.invalid_frame = 1'b0;
                            nx.mode          = MODE_OAM;
                            nx.phase         = PH_OAM;
                            nx.countdown     = dur(cfg.oam_cycles);
                            stat             = item.irq_on_oam && !item.irq_on_vblank;
                        end
                        else
                        begin
                            frame        = 1'b1;
                            nx.mode      = MODE_HBLANK;
                            nx.phase     = PH_OFF;
                            nx.countdown = dur(cfg.line_cycles);
                        end
                    end
                    else
                    begin
                        nx.line_counter = vb_line;
                        nx.coincidence  = vb_eval[1];
                        stat            = vb_eval[0];
                        if (st.line_counter == LAST_SHORT_PREV)
                            nx.countdown = dur(cfg.short_line_cycles);
                        else if (st.line_counter == LAST_LINE)
                            nx.countdown = (cfg.line_cycles > cfg.short_line_cycles) ?
                                           (cfg.line_cycles - cfg.short_line_cycles) :
                                           CfgWidth'(1);
                        else
                            nx.countdown = dur(cfg.line_cycles);
                    end
                end
                default:
                begin
                    nx = st;
                end
            endcase
        end
    end

    always_comb
    begin
        res.mode_bits   = nx.mode;
        res.line_number = nx.line_counter;
        res.lyc_match   = nx.coincidence;
        res.stat_irq    = stat;
        res.vblank_irq  = vbi;
        res.render_line = rend;
        res.frame_ready = frame;
        res.display_on  = (nx.phase != PH_OFF);
    end

endmodule

@@ hdl/lcd_scanline_mode_sequencer.sv @@
// Top level of the LCD scanline mode sequencer: request registers and state.
//
// Usage:
//   Each input request is one display controller tick carrying the live LCD
//   enable, the line compare value and four status interrupt enables. Each
//   accepted request yields exactly one result request with the mode bits,
//   line number, coincidence flag and the stat, vblank, render-line and
//   frame-ready pulses for that tick.
//   Both channels use valid/stall; a request moves on a rising edge with
//   valid high and stall low.
//   A request passes through the input register, then the result register;
//   out_valid rises once the result register is loaded. Throughput: one
//   request per cycle while the receiver does not stall, set by the
//   combinational state update between the two registers.
//   When the receiver stalls a waiting result, the result register holds. An
//   occupied input register then raises in_stall in the same cycle (out_stall
//   feeds in_stall combinationally); an empty one takes one more request first.
//   Reset: sequencer starts in the off phase, countdown at line_cycles,
//   line 0, mode 0; timing registers return to 80/172/204/456/56.
//   Timing registers are written through cfg_write/cfg_index/cfg_data; the user
//   must write them only while the block is idle, which the block does not enforce.
module lcd_scanline_mode_sequencer
#(
    parameter int VISIBLE_LINES = 144
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            cfg_write,
    input  logic [lsms_pkg::IndexWidth-1:0] cfg_index,
    input  logic [lsms_pkg::CfgWidth-1:0]   cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            lcd_enable,
    input  logic [lsms_pkg::LineWidth-1:0]  lyc_value,
    input  logic                            irq_on_lyc,
    input  logic                            irq_on_oam,
    input  logic                            irq_on_vblank,
    input  logic                            irq_on_hblank,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [1:0]                      mode_bits,
    output logic [lsms_pkg::LineWidth-1:0]  line_number,
    output logic                            lyc_match,
    output logic                            stat_irq,
    output logic                            vblank_irq,
    output logic                            render_line,
    output logic                            frame_ready,
    output logic                            display_on
);
    import lsms_pkg::*;

    cfg_t       cfg;
    item_t      item_reg;
    logic       in_full_reg;
    logic       in_full_next;
    seq_state_t st_reg;
    seq_state_t st_next;
    result_t    res_next;
    result_t    res_reg;
    logic       out_valid_reg;
    logic       in_accept;
    logic       advance;

    lsms_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lsms_step #(.VISIBLE_LINES(VISIBLE_LINES)) u_step
    (
        .st   (st_reg),
        .item (item_reg),
        .cfg  (cfg),
        .nx   (st_next),
        .res  (res_next)
    );

    // held request steps the sequencer when the result slot is empty or its result is taken
    assign advance      = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall     = in_full_reg && !advance;
    assign in_accept    = in_valid && !in_stall;
    assign in_full_next = in_accept ? 1'b1 : (advance ? 1'b0 : in_full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else
            in_full_reg <= in_full_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg.lcd_enable    <= lcd_enable;
            item_reg.lyc_value     <= lyc_value;
            item_reg.irq_on_lyc    <= irq_on_lyc;
            item_reg.irq_on_oam    <= irq_on_oam;
            item_reg.irq_on_vblank <= irq_on_vblank;
            item_reg.irq_on_hblank <= irq_on_hblank;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase         <= PH_OFF;
            st_reg.countdown     <= LINE_RESET;
            st_reg.line_counter  <= '0;
            st_reg.mode          <= MODE_HBLANK;
            st_reg.coincidence   <= 1'b0;
            st_reg.invalid_frame <= 1'b0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid   = out_valid_reg;
    assign mode_bits   = res_reg.mode_bits;
    assign line_number = res_reg.line_number;
    assign lyc_match   = res_reg.lyc_match;
    assign stat_irq    = res_reg.stat_irq;
    assign vblank_irq  = res_reg.vblank_irq;
    assign render_line = res_reg.render_line;
    assign frame_ready = res_reg.frame_ready;
    assign display_on  = res_reg.display_on;

    // display off always reports line 0, mode 0
    a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !display_on) |-> (mode_bits == MODE_HBLANK && line_number == '0))
        else $error("off phase with nonzero mode or line");

    // vblank pulse only on entry to the first vblank line
    a_vbi_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && vblank_irq) |->
            (mode_bits == MODE_VBLANK && line_number == VISIBLE_LINES[LineWidth-1:0]))
        else $error("vblank pulse outside vblank entry");

    // render pulse only when entering hblank
    a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && render_line) |-> (mode_bits == MODE_HBLANK && display_on))
        else $error("render pulse outside hblank entry");

    // sequencer state only moves when a result is produced
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("state changed without a step");

endmodule
